[src/shfc_pkg.sv]
// Shared constants and types for the stereo HRIR FIR convolver.
// Used by shfc_mac and the top level; depends on nothing else.
package shfc_pkg;

    localparam int TAPS        = 200;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 18;
    localparam int IDX_BITS    = 8;
    localparam int TAP_W       = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS    = PROD_BITS + TAP_W;
    localparam int SHIFT       = COEF_BITS - 1;

    localparam logic [TAP_W-1:0]  LAST_SLOT = TAP_W'(TAPS - 1);
    localparam logic [IDX_BITS:0] TAPS_LIM  = (IDX_BITS + 1)'(TAPS);

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;
    localparam logic CH_LEFT     = 1'b0;
    localparam logic CH_RIGHT    = 1'b1;

    typedef struct packed {
        logic start;    // clear the accumulator for a new sample
        logic rd_vld;   // operands from the memories are valid this cycle
    } mac_ctl_t;

endpackage

[src/shfc_mac.sv]
// Shared multiply-accumulate unit for one channel, with round and saturate.
// Depends on shfc_pkg.
module shfc_mac (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  shfc_pkg::mac_ctl_t                    ctl,
    input  logic signed [shfc_pkg::SAMPLE_BITS-1:0] sample,
    input  logic signed [shfc_pkg::COEF_BITS-1:0]   coef,
    output logic signed [shfc_pkg::SAMPLE_BITS-1:0] result,
    output logic                                  busy
);
    import shfc_pkg::*;

    localparam logic signed [ACC_BITS-1:0] ROUND_K = ACC_BITS'(1) <<< (SHIFT - 1);
    localparam logic signed [ACC_BITS-1:0] MAX_V =
        ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_BITS-1:0] MIN_V = -MAX_V - ACC_BITS'(1);

    logic signed [PROD_BITS-1:0] prod_reg;
    logic                        prod_vld_reg;
    logic signed [ACC_BITS-1:0]  acc_reg;
    logic signed [ACC_BITS-1:0]  acc_next;
    logic signed [ACC_BITS-1:0]  rounded;
    logic signed [ACC_BITS-1:0]  shifted;

    always_ff @(posedge clk)
    begin
        if (ctl.rd_vld)
        begin
            prod_reg <= sample * coef;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= ctl.rd_vld;
            acc_reg      <= acc_next;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.start)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + ACC_BITS'(prod_reg);
        end
    end

    // round half up, then clamp to the sample range
    always_comb
    begin
        rounded = acc_reg + ROUND_K;
        shifted = rounded >>> SHIFT;
        if (shifted > MAX_V)
        begin
            result = MAX_V[SAMPLE_BITS-1:0];
        end
        else if (shifted < MIN_V)
        begin
            result = MIN_V[SAMPLE_BITS-1:0];
        end
        else
        begin
            result = shifted[SAMPLE_BITS-1:0];
        end
    end

    assign busy = prod_vld_reg;

endmodule

[src/stereo_hrir_fir_convolver.sv]
// Stereo HRIR FIR convolver: top level with sequencer, delay-line and tap memories.
// Depends on shfc_pkg and shfc_mac.
//
// Each sample beat (kind = 0) is handled in steps: accept and store the pair,
// step the two shared multiply-accumulate units through the taps (one memory
// read per channel per clock), drain the read, product and accumulator
// registers, and load the output register once its last result is taken. A
// coefficient beat (kind = 1) is written straight to its tap memory and gives
// no result; an index of 200 or more is dropped. After reset a clearing pass
// zeroes delay lines and taps, with in_stall held high until it is done. A
// finished result waits in the output register while the next beat is taken.
module stereo_hrir_fir_convolver (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    kind,
    input  logic signed [shfc_pkg::SAMPLE_BITS-1:0] left_sample,
    input  logic signed [shfc_pkg::SAMPLE_BITS-1:0] right_sample,
    input  logic                                    coef_channel,
    input  logic        [shfc_pkg::IDX_BITS-1:0]    coef_index,
    input  logic signed [shfc_pkg::COEF_BITS-1:0]   coef_value,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [shfc_pkg::SAMPLE_BITS-1:0] left_out,
    output logic signed [shfc_pkg::SAMPLE_BITS-1:0] right_out
);
    import shfc_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_RUN   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [TAP_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [TAP_W-1:0] slot_reg, slot_next, slot_inc;
    logic [TAP_W-1:0] rd_slot_reg, rd_slot_next;
    logic [TAP_W-1:0] tap_cnt_reg, tap_cnt_next;
    logic             rd_vld_reg;
    logic             rd_en;
    logic             out_vld_reg, out_vld_next;
    logic signed [SAMPLE_BITS-1:0] left_out_reg, right_out_reg;

    logic accept, smp_accept, coef_ok, clearing, load_out;

    // memories
    logic signed [SAMPLE_BITS-1:0] dly_l_mem [TAPS];
    logic signed [SAMPLE_BITS-1:0] dly_r_mem [TAPS];
    logic signed [COEF_BITS-1:0]   tap_l_mem [TAPS];
    logic signed [COEF_BITS-1:0]   tap_r_mem [TAPS];
    logic signed [SAMPLE_BITS-1:0] dly_l_q, dly_r_q;
    logic signed [COEF_BITS-1:0]   tap_l_q, tap_r_q;

    logic                          dly_we, tap_l_we, tap_r_we;
    logic [TAP_W-1:0]              dly_wa, tap_wa;
    logic signed [SAMPLE_BITS-1:0] dly_l_wd, dly_r_wd;
    logic signed [COEF_BITS-1:0]   tap_wd;

    mac_ctl_t mac_ctl;
    logic signed [SAMPLE_BITS-1:0] left_res, right_res;
    logic left_busy, right_busy;

    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign smp_accept = accept && (kind == KIND_SAMPLE);
    assign coef_ok    = accept && (kind == KIND_COEF) && ({1'b0, coef_index} < TAPS_LIM);
    assign clearing   = (state_reg == ST_CLEAR);
    assign rd_en      = (state_reg == ST_RUN);
    assign load_out   = (state_reg == ST_DONE) && (!out_vld_reg || !out_stall);

    assign slot_inc = (slot_reg == LAST_SLOT) ? '0 : slot_reg + TAP_W'(1);

    // memory write ports: clearing pass or beat
    always_comb
    begin
        dly_we   = clearing || smp_accept;
        dly_wa   = clearing ? clr_cnt_reg : slot_inc;
        dly_l_wd = clearing ? '0 : left_sample;
        dly_r_wd = clearing ? '0 : right_sample;
        tap_l_we = clearing || (coef_ok && (coef_channel == CH_LEFT));
        tap_r_we = clearing || (coef_ok && (coef_channel == CH_RIGHT));
        tap_wa   = clearing ? clr_cnt_reg : coef_index[TAP_W-1:0];
        tap_wd   = clearing ? '0 : coef_value;
    end

    always_ff @(posedge clk)
    begin
        if (dly_we)
        begin
            dly_l_mem[dly_wa] <= dly_l_wd;
            dly_r_mem[dly_wa] <= dly_r_wd;
        end
        if (rd_en)
        begin
            dly_l_q <= dly_l_mem[rd_slot_reg];
            dly_r_q <= dly_r_mem[rd_slot_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tap_l_we)
        begin
            tap_l_mem[tap_wa] <= tap_wd;
        end
        if (tap_r_we)
        begin
            tap_r_mem[tap_wa] <= tap_wd;
        end
        if (rd_en)
        begin
            tap_l_q <= tap_l_mem[tap_cnt_reg];
            tap_r_q <= tap_r_mem[tap_cnt_reg];
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        slot_next    = slot_reg;
        rd_slot_next = rd_slot_reg;
        tap_cnt_next = tap_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + TAP_W'(1);
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (smp_accept)
                begin
                    slot_next    = slot_inc;
                    rd_slot_next = slot_inc;
                    tap_cnt_next = '0;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // walk from the newest sample back in time
                rd_slot_next = (rd_slot_reg == '0) ? LAST_SLOT : rd_slot_reg - TAP_W'(1);
                tap_cnt_next = tap_cnt_reg + TAP_W'(1);
                if (tap_cnt_reg == LAST_SLOT)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !left_busy && !right_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (load_out)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            slot_reg    <= '0;
            rd_slot_reg <= '0;
            tap_cnt_reg <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            slot_reg    <= slot_next;
            rd_slot_reg <= rd_slot_next;
            tap_cnt_reg <= tap_cnt_next;
            rd_vld_reg  <= rd_en;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            left_out_reg  <= left_res;
            right_out_reg <= right_res;
        end
    end

    assign mac_ctl.start  = smp_accept;
    assign mac_ctl.rd_vld = rd_vld_reg;

    shfc_mac u_mac_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .sample (dly_l_q),
        .coef   (tap_l_q),
        .result (left_res),
        .busy   (left_busy)
    );

    shfc_mac u_mac_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .sample (dly_r_q),
        .coef   (tap_r_q),
        .result (right_res),
        .busy   (right_busy)
    );

    assign out_valid = out_vld_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule
